### hw/rtl/flv_tag_stream_walker_defines.svh
// assertion macros for the flv tag stream walker checker
`ifndef FLV_TAG_STREAM_WALKER_DEFINES_SVH
`define FLV_TAG_STREAM_WALKER_DEFINES_SVH

// same-cycle implication, sampled on i_clk, off while reset is low
`define FLVW_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("flvw check failed");

// next-cycle implication, sampled on i_clk, off while reset is low
`define FLVW_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("flvw check failed");

`endif

### hw/rtl/flvw_pkg.sv
// shared types, codes and small tables of the flv tag stream walker
`default_nettype none

package flvw_pkg;

    // parser phases
    localparam logic [2:0] PH_HEADER = 3'd0;
    localparam logic [2:0] PH_SKIP   = 3'd1;
    localparam logic [2:0] PH_TAGHDR = 3'd2;
    localparam logic [2:0] PH_CODEC  = 3'd3;
    localparam logic [2:0] PH_DEAD   = 3'd4;

    // record kinds
    localparam logic [1:0] REC_HDR = 2'd0;
    localparam logic [1:0] REC_BAD = 2'd1;
    localparam logic [1:0] REC_TAG = 2'd2;
    localparam logic [1:0] REC_SUM = 2'd3;

    // tag type bytes
    localparam logic [7:0] TAG_AUDIO  = 8'd8;
    localparam logic [7:0] TAG_VIDEO  = 8'd9;
    localparam logic [7:0] TAG_SCRIPT = 8'd18;

    localparam logic [15:0] TAG_LIMIT_RST = 16'd500;
    localparam logic [31:0] HDR_MIN_LEN   = 32'd9;
    localparam logic [3:0]  HDR_LAST_IDX  = 4'd8;
    localparam logic [3:0]  TAG_LAST_IDX  = 4'd10;

    // one result item
    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  type_byte;
        logic [23:0] size_a;
        logic [31:0] time_b;
        logic [31:0] offset_c;
        logic [3:0]  codec;
        logic [15:0] rate_hz;
        logic        s16;
        logic        stereo;
        logic        codec_valid;
        logic        last;
    } t_rec;

    // up to two results handed from the parser to the output buffer
    typedef struct packed {
        logic [1:0] cnt;
        t_rec       rec0;
        t_rec       rec1;
    } t_push;

    // audio sample rate code to hertz
    function automatic logic [15:0] rate_hz(input logic [1:0] code);
        logic [15:0] r;
        case (code)
            2'd0:    r = 16'd5500;
            2'd1:    r = 16'd11025;
            2'd2:    r = 16'd22050;
            default: r = 16'd44100;
        endcase
        return r;
    endfunction

    // expected signature byte "FLV"
    function automatic logic [7:0] sig_byte(input logic [1:0] idx);
        logic [7:0] r;
        case (idx)
            2'd0:    r = 8'h46;
            2'd1:    r = 8'h4C;
            2'd2:    r = 8'h56;
            default: r = 8'h00;
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

### hw/rtl/flvw_parse.sv
// byte-wise parser state and record building for one item per cycle while i_go is high
`default_nettype none

module flvw_parse (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic [15:0]    i_tag_limit,
    input  wire logic           i_go,
    input  wire logic [7:0]     i_byte,
    input  wire logic           i_eos,
    output flvw_pkg::t_push     o_push
);
    import flvw_pkg::*;

    logic [2:0]  r_phase, n_phase;
    logic [3:0]  r_idx, n_idx;
    logic [31:0] r_hlen, n_hlen;
    logic [31:0] r_skip, n_skip;
    logic [31:0] r_off, n_off;
    logic [7:0]  r_type, n_type;
    logic [23:0] r_size, n_size;
    logic [31:0] r_time, n_time;
    logic [31:0] r_start, n_start;
    logic [15:0] r_seen, n_seen;
    logic [15:0] r_video, n_video;
    logic [15:0] r_audio, n_audio;
    logic [15:0] r_script, n_script;
    logic        r_adone, n_adone;
    logic        r_vdone, n_vdone;

    t_rec        rec_a, rec_b;
    logic        has_a, has_b;
    logic        fin, with_codec, counted, need;
    logic [31:0] skip_dec;

    // next state and records for the byte in the input register
    always_comb begin
        n_phase = r_phase; n_idx = r_idx; n_hlen = r_hlen; n_skip = r_skip;
        n_off = r_off + 32'd1;
        n_type = r_type; n_size = r_size; n_time = r_time; n_start = r_start;
        n_seen = r_seen; n_video = r_video; n_audio = r_audio; n_script = r_script;
        n_adone = r_adone; n_vdone = r_vdone;
        rec_a = '0; rec_b = '0; has_a = 1'b0; has_b = 1'b0;
        fin = 1'b0; with_codec = 1'b0;
        counted = r_seen < i_tag_limit;
        need = 1'b0;
        skip_dec = (r_skip != 32'd0) ? r_skip - 32'd1 : r_skip;

        unique case (r_phase)
            PH_HEADER: begin
                if (r_idx < 4'd3 && i_byte != sig_byte(r_idx[1:0])) begin
                    has_a = 1'b1;
                    rec_a.kind = REC_BAD;
                    n_phase = PH_DEAD;
                end else begin
                    if (r_idx == 4'd3) begin
                        n_type = i_byte;
                    end else if (r_idx == 4'd4) begin
                        n_size = {16'd0, i_byte};
                    end else if (r_idx >= 4'd5) begin
                        n_hlen = {r_hlen[23:0], i_byte};
                    end
                    n_idx = r_idx + 4'd1;
                    // header complete: report it and skip to the first tag
                    if (r_idx >= HDR_LAST_IDX) begin
                        has_a = 1'b1;
                        rec_a.kind = REC_HDR;
                        rec_a.type_byte = r_type;
                        rec_a.size_a = r_size;
                        rec_a.offset_c = n_hlen;
                        n_skip = (n_hlen >= HDR_MIN_LEN) ? n_hlen - 32'd5 : 32'd4;
                        n_phase = PH_SKIP;
                        n_type = '0;
                        n_size = '0;
                    end
                end
            end
            PH_SKIP: begin
                n_skip = skip_dec;
                if (skip_dec == 32'd0) begin
                    n_phase = PH_TAGHDR;
                    n_idx = '0;
                end
            end
            PH_TAGHDR: begin
                if (r_idx == 4'd0) begin
                    n_type = i_byte;
                    n_start = r_off;
                    n_size = '0;
                    n_time = '0;
                end else if (r_idx <= 4'd3) begin
                    n_size = {r_size[15:0], i_byte};
                end else if (r_idx <= 4'd6) begin
                    n_time = {8'd0, r_time[15:0], i_byte};
                end else if (r_idx == 4'd7) begin
                    n_time = r_time | {i_byte, 24'd0};
                end
                n_idx = r_idx + 4'd1;
                // tag header complete
                if (r_idx >= TAG_LAST_IDX) begin
                    need = counted && r_size != 24'd0 &&
                           ((r_type == TAG_AUDIO && !r_adone) ||
                            (r_type == TAG_VIDEO && !r_vdone));
                    if (need && !i_eos) begin
                        n_phase = PH_CODEC;
                    end else begin
                        fin = counted;
                        n_skip = {8'd0, r_size} + 32'd4;
                        n_phase = PH_SKIP;
                    end
                    n_idx = '0;
                end
            end
            PH_CODEC: begin
                fin = 1'b1;
                with_codec = 1'b1;
                n_skip = {8'd0, r_size} + 32'd3;
                n_phase = PH_SKIP;
            end
            default: begin
            end
        endcase

        // tag record and per-type counts
        if (fin) begin
            has_a = 1'b1;
            rec_a.kind = REC_TAG;
            rec_a.type_byte = r_type;
            rec_a.size_a = r_size;
            rec_a.time_b = r_time;
            rec_a.offset_c = r_start;
            if (r_type == TAG_AUDIO) begin
                n_audio = r_audio + 16'd1;
                if (with_codec) begin
                    rec_a.codec = i_byte[7:4];
                    rec_a.rate_hz = rate_hz(i_byte[3:2]);
                    rec_a.s16 = i_byte[1];
                    rec_a.stereo = i_byte[0];
                    rec_a.codec_valid = 1'b1;
                    n_adone = 1'b1;
                end
            end else if (r_type == TAG_VIDEO) begin
                n_video = r_video + 16'd1;
                if (with_codec) begin
                    rec_a.codec = i_byte[3:0];
                    rec_a.codec_valid = 1'b1;
                    n_vdone = 1'b1;
                end
            end else if (r_type == TAG_SCRIPT) begin
                n_script = r_script + 16'd1;
            end
            n_seen = r_seen + 16'd1;
        end

        // final byte: short file or summary (nothing after a bad signature), then back to reset state
        if (i_eos) begin
            if (n_phase == PH_HEADER) begin
                has_b = 1'b1;
                rec_b.kind = REC_BAD;
            end else if (n_phase != PH_DEAD) begin
                has_b = 1'b1;
                rec_b.kind = REC_SUM;
                rec_b.size_a = {8'd0, n_video};
                rec_b.time_b = {16'd0, n_audio};
                rec_b.offset_c = {16'd0, n_script};
            end
            n_phase = PH_HEADER; n_idx = '0; n_hlen = '0; n_skip = '0; n_off = '0;
            n_type = '0; n_size = '0; n_time = '0; n_start = '0;
            n_seen = '0; n_video = '0; n_audio = '0; n_script = '0;
            n_adone = 1'b0; n_vdone = 1'b0;
        end

        rec_a.last = !has_b;
        rec_b.last = 1'b1;
    end

    // pack the results in order
    always_comb begin
        o_push.cnt  = {1'b0, has_a} + {1'b0, has_b};
        o_push.rec0 = has_a ? rec_a : rec_b;
        o_push.rec1 = rec_b;
    end

    // parser state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_HEADER; r_idx <= '0; r_hlen <= '0; r_skip <= '0; r_off <= '0;
            r_type <= '0; r_size <= '0; r_time <= '0; r_start <= '0;
            r_seen <= '0; r_video <= '0; r_audio <= '0; r_script <= '0;
            r_adone <= 1'b0; r_vdone <= 1'b0;
        end else if (i_go) begin
            r_phase <= n_phase; r_idx <= n_idx; r_hlen <= n_hlen; r_skip <= n_skip;
            r_off <= n_off;
            r_type <= n_type; r_size <= n_size; r_time <= n_time; r_start <= n_start;
            r_seen <= n_seen; r_video <= n_video; r_audio <= n_audio; r_script <= n_script;
            r_adone <= n_adone; r_vdone <= n_vdone;
        end
    end

endmodule

`default_nettype wire

### hw/rtl/flvw_out_buf.sv
// two-entry result buffer that parts the parser from the output channel
`default_nettype none

module flvw_out_buf (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire flvw_pkg::t_push i_push,
    input  wire logic           i_go,
    input  wire logic           i_out_stall,
    output logic                o_fit,
    output logic                o_valid,
    output flvw_pkg::t_rec      o_rec
);
    import flvw_pkg::*;

    logic [1:0] r_cnt, n_cnt;
    t_rec       r_slot0, n_slot0;
    t_rec       r_slot1, n_slot1;
    logic       pop;
    logic [1:0] cnt_left;
    logic [2:0] cnt_sum;

    // room check for the results of the item now in the input register
    always_comb begin
        pop      = (r_cnt != 2'd0) && !i_out_stall;
        cnt_left = r_cnt - {1'b0, pop};
        cnt_sum  = {1'b0, cnt_left} + {1'b0, i_push.cnt};
        o_fit    = cnt_sum <= 3'd2;
    end

    // shift out on pop, then append the new results
    always_comb begin
        n_slot0 = pop ? r_slot1 : r_slot0;
        n_slot1 = r_slot1;
        n_cnt   = cnt_left;
        if (i_go) begin
            if (i_push.cnt != 2'd0) begin
                if (cnt_left == 2'd0) begin
                    n_slot0 = i_push.rec0;
                end else begin
                    n_slot1 = i_push.rec0;
                end
            end
            if (i_push.cnt == 2'd2) begin
                n_slot1 = i_push.rec1;
            end
            n_cnt = cnt_sum[1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_slot0 <= n_slot0;
        r_slot1 <= n_slot1;
    end

    assign o_valid = r_cnt != 2'd0;
    assign o_rec   = r_slot0;

endmodule

`default_nettype wire

### hw/rtl/flv_tag_stream_walker.sv
// top level of the flv tag stream walker
//
// Walks an FLV file one byte per item on the input channel (i_in_valid,
// o_in_stall, i_data_byte, i_end_of_stream) and gives records on the output
// channel (o_out_valid, i_out_stall and the record fields): file header info,
// "not an FLV file", one record per counted tag, and a summary on the last
// byte. An item gives zero, one or two records; o_last_of_run marks the last.
// The tag limit is written through i_cfg_wdata when i_cfg_we is high; the user is to write it only
// while idle, which the block itself does not enforce. It resets to 500.
// A record passes the input register and then the result buffer before it is
// on the output; a full buffer holds the item in the input register.
// Throughput: one item per cycle while the receiver keeps up; a byte giving
// two records holds the input while the two-entry result buffer still holds
// a record that is not being taken. The buffer depth sets this figure.
// Reset (synchronous, active low) empties both channels and puts the parser
// back at the file header. When the receiver stalls, the result buffer fills
// and then the input is stalled; no record is lost or repeated.
// After the final byte of a file the parser is back at its reset state, so
// the next file may follow at once.
`default_nettype none

module flv_tag_stream_walker (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_stall,
    input  wire logic [7:0]  i_data_byte,
    input  wire logic        i_end_of_stream,
    input  wire logic        i_cfg_we,
    input  wire logic [15:0] i_cfg_wdata,
    output logic             o_out_valid,
    input  wire logic        i_out_stall,
    output logic [1:0]       o_record_kind,
    output logic [7:0]       o_tag_type,
    output logic [23:0]      o_size_or_count_a,
    output logic [31:0]      o_time_or_count_b,
    output logic [31:0]      o_offset_or_count_c,
    output logic [3:0]       o_codec_code,
    output logic [15:0]      o_sample_rate_hz,
    output logic             o_sample_16bit,
    output logic             o_stereo,
    output logic             o_codec_valid,
    output logic             o_last_of_run
);
    import flvw_pkg::*;

    logic        r_in_valid;
    logic [7:0]  r_in_byte;
    logic        r_in_eos;
    logic [15:0] r_tag_limit;
    logic        accept, go, fit;
    t_push       push;
    t_rec        out_rec;

    // input register handshake
    assign go         = r_in_valid && fit;
    assign o_in_stall = r_in_valid && !go;
    assign accept     = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (accept) begin
            r_in_valid <= 1'b1;
        end else if (go) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_in_byte <= i_data_byte;
            r_in_eos  <= i_end_of_stream;
        end
    end

    // tag limit register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tag_limit <= TAG_LIMIT_RST;
        end else if (i_cfg_we) begin
            r_tag_limit <= i_cfg_wdata;
        end
    end

    flvw_parse u_parse (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_tag_limit (r_tag_limit),
        .i_go        (go),
        .i_byte      (r_in_byte),
        .i_eos       (r_in_eos),
        .o_push      (push)
    );

    flvw_out_buf u_out_buf (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_go        (go),
        .i_out_stall (i_out_stall),
        .o_fit       (fit),
        .o_valid     (o_out_valid),
        .o_rec       (out_rec)
    );

    // record fields
    assign o_record_kind       = out_rec.kind;
    assign o_tag_type          = out_rec.type_byte;
    assign o_size_or_count_a   = out_rec.size_a;
    assign o_time_or_count_b   = out_rec.time_b;
    assign o_offset_or_count_c = out_rec.offset_c;
    assign o_codec_code        = out_rec.codec;
    assign o_sample_rate_hz    = out_rec.rate_hz;
    assign o_sample_16bit      = out_rec.s16;
    assign o_stereo            = out_rec.stereo;
    assign o_codec_valid       = out_rec.codec_valid;
    assign o_last_of_run       = out_rec.last;

endmodule

`default_nettype wire

### hw/rtl/flvw_checker.sv
// port-level checks of the flv tag stream walker and their bind
`default_nettype none

`include "flv_tag_stream_walker_defines.svh"

module flvw_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_out_stall,
    input wire logic        o_out_valid,
    input wire logic [1:0]  o_record_kind,
    input wire logic [7:0]  o_tag_type,
    input wire logic [31:0] o_time_or_count_b,
    input wire logic [31:0] o_offset_or_count_c,
    input wire logic [3:0]  o_codec_code,
    input wire logic [15:0] o_sample_rate_hz,
    input wire logic        o_sample_16bit,
    input wire logic        o_stereo,
    input wire logic        o_codec_valid
);
    import flvw_pkg::*;

    // a stalled item stays on the output unchanged
    `FLVW_NEXT(a_out_hold, o_out_valid && i_out_stall, o_out_valid && $stable(o_record_kind) && $stable(o_time_or_count_b) && $stable(o_offset_or_count_c))

    // codec information only travels on tag records
    `FLVW_IMPL(a_codec_on_tag, o_out_valid && o_record_kind != REC_TAG, !o_codec_valid)

    // codec fields are clear when no codec information is carried
    `FLVW_IMPL(a_codec_clear, o_out_valid && !o_codec_valid, o_codec_code == 4'd0 && o_sample_rate_hz == 16'd0 && !o_sample_16bit && !o_stereo)

    // a video record carries no audio details
    `FLVW_IMPL(a_video_no_audio, o_out_valid && o_codec_valid && o_tag_type == TAG_VIDEO, o_sample_rate_hz == 16'd0 && !o_sample_16bit && !o_stereo)

    // the output is empty right after reset
    `FLVW_IMPL(a_reset_empty, $rose(i_rst_n), !o_out_valid)

endmodule

bind flv_tag_stream_walker flvw_checker u_flvw_checker (
    .i_clk               (i_clk),
    .i_rst_n             (i_rst_n),
    .i_out_stall         (i_out_stall),
    .o_out_valid         (o_out_valid),
    .o_record_kind       (o_record_kind),
    .o_tag_type          (o_tag_type),
    .o_time_or_count_b   (o_time_or_count_b),
    .o_offset_or_count_c (o_offset_or_count_c),
    .o_codec_code        (o_codec_code),
    .o_sample_rate_hz    (o_sample_rate_hz),
    .o_sample_16bit      (o_sample_16bit),
    .o_stereo            (o_stereo),
    .o_codec_valid       (o_codec_valid)
);

`default_nettype wire
